/* src/tilt_to_color_mixer_core_defines.svh */
// Assertion macros shared by the tilt-to-colour mixer RTL.
`ifndef TILT_TO_COLOR_MIXER_CORE_DEFINES_SVH
`define TILT_TO_COLOR_MIXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define TCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCM_ASSERT_NOW(label, ante, cons, msg)
`define TCM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/tcm_pkg.sv */
// Types, codes and constant tables of the tilt-to-colour mixer.
package tcm_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_REST   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef logic signed [10:0] accel_t;
    typedef logic signed [11:0] peak_t;
    typedef logic signed [12:0] level_t;
    typedef logic        [7:0]  duty_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] CFG_DECAY_PERIOD = 3'd0;
    localparam logic [2:0] CFG_LOWER_SENS   = 3'd1;
    localparam logic [2:0] CFG_RAISE_SENS   = 3'd2;
    localparam logic [2:0] CFG_REST_THR     = 3'd3;
    localparam logic [2:0] CFG_BIAS_RED     = 3'd4;
    localparam logic [2:0] CFG_BIAS_GREEN   = 3'd5;
    localparam logic [2:0] CFG_BIAS_BLUE    = 3'd6;

    localparam logic [15:0]       DECAY_PERIOD_RST = 16'd64;
    localparam logic [9:0]        LOWER_SENS_RST   = 10'd160;
    localparam logic [9:0]        RAISE_SENS_RST   = 10'd32;
    localparam logic [9:0]        REST_THR_RST     = 10'd5;
    localparam logic signed [7:0] BIAS_RED_RST     = 8'sd10;
    localparam logic signed [7:0] BIAS_GREEN_RST   = 8'sd6;
    localparam logic signed [7:0] BIAS_BLUE_RST    = -8'sd6;

    localparam accel_t REST_Z_RST   = -11'sd40;
    localparam level_t LEVEL_OFFSET = 13'sd128;
    localparam level_t DUTY_MAX     = 13'sd255;

    localparam duty_t GAMMA_ROM [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
        8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
        8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
        8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
        8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
        8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
        8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
        8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
        8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
        8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
        8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
        8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
        8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
    };

    // Magnitude of a signed deflection; deflections never exceed 1020 in size.
    function automatic logic [10:0] peak_mag(peak_t v);
        peak_t neg;
        neg = -v;
        peak_mag = v[11] ? neg[10:0] : v[10:0];
    endfunction

endpackage

/* src/tcm_duty.sv */
// One colour channel: bias, clamp to 0..255 and gamma mapping.
module tcm_duty
    import tcm_pkg::*;
(
    input  level_t             level,
    input  logic signed [7:0]  bias,
    output duty_t              duty
);

    level_t sum;
    duty_t  clamped;

    assign sum = level + level_t'(bias);

    always_comb begin
        priority if (sum < 0) begin
            clamped = '0;
        end else if (sum > DUTY_MAX) begin
            clamped = 8'hff;
        end else begin
            clamped = sum[7:0];
        end
    end

    assign duty = GAMMA_ROM[clamped];

endmodule

/* src/tilt_to_color_mixer_core.sv */
// Top level of the tilt-to-colour mixer: sample intake, auto-ranging, peak tracking and RGB mix.
//
// The block takes one transaction per clock cycle on the s_ channel and returns exactly one
// result transaction on the m_ channel for each, in order. A transaction first lands in an
// input register; once the result register is free or being taken, the whole update for it
// (axis sample scaling, auto-range decision and, at the end of a round, peak tracking for a
// sample; rest capture for a rest; decay, three-way mix, bias, clamp and gamma lookup for a
// tick) is done in one pass of logic and written into the state registers, which are also
// the result fields. m_valid is set by that same write, and the sustained rate is one
// transaction per cycle as long as m_ready is high. The longest path, and so the clock limit,
// is the tick path through the decay step, the mix adders, the bias adder and the 256-entry
// gamma table. Configuration registers are written through cfg_wr_en, cfg_index and cfg_wdata;
// the user must write them only while the block is idle, which the block itself does not enforce;
// the signed biases take the low eight bits of cfg_wdata and the thresholds the low ten.
`include "tilt_to_color_mixer_core_defines.svh"

module tilt_to_color_mixer_core
    import tcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_sample,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_duty,
    output logic [7:0]  m_green_duty,
    output logic [7:0]  m_blue_duty,
    output logic        m_low_sensitivity,
    output logic [1:0]  m_next_axis
);

    // Configuration registers.
    logic [15:0]       decay_period_reg;
    logic [9:0]        lower_sens_reg;
    logic [9:0]        raise_sens_reg;
    logic [9:0]        rest_thr_reg;
    logic signed [7:0] bias_red_reg;
    logic signed [7:0] bias_green_reg;
    logic signed [7:0] bias_blue_reg;

    // Input register.
    logic        in_vld_reg;
    action_t     in_act_reg;
    logic [7:0]  in_smp_reg;

    // Block state; the duty, mode and axis registers double as the result register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  axis_reg, axis_next;
    accel_t      latest_reg [3];
    accel_t      latest_next [3];
    accel_t      rest_reg [3];
    accel_t      rest_next [3];
    peak_t       peak_reg [3];
    peak_t       peak_next [3];
    logic        low_sens_reg, low_sens_next;
    logic        allow_raise_reg, allow_raise_next;
    logic        want_lower_reg, want_lower_next;
    logic [15:0] tick_cnt_reg, tick_cnt_next;
    duty_t       duty_reg [3];
    duty_t       duty_next [3];

    logic        adv;

    // The stage in front of the state registers moves when the result register is free or is
    // being taken in the same cycle.
    assign adv     = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    // Tick path: decay, half weights, mix and per-channel duty.
    logic [15:0] tick_inc;
    logic        decay_now;
    peak_t       pk_dec [3];
    peak_t       pk_half [3];
    level_t      lvl [3];
    duty_t       duty_w [3];

    assign tick_inc  = tick_cnt_reg + 16'd1;
    assign decay_now = tick_inc >= decay_period_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!decay_now || peak_reg[i] == '0) begin
                pk_dec[i] = peak_reg[i];
            end else if (peak_reg[i][11]) begin
                pk_dec[i] = peak_reg[i] + 12'sd1;
            end else begin
                pk_dec[i] = peak_reg[i] - 12'sd1;
            end
            // Halving rounds toward zero, so negative peaks get one added before the shift.
            pk_half[i] = (pk_dec[i] + peak_t'({11'd0, pk_dec[i][11]})) >>> 1;
        end
        lvl[0] = level_t'(pk_dec[0]) + LEVEL_OFFSET
                 - level_t'(pk_half[1]) - level_t'(pk_half[2]);
        lvl[1] = level_t'(pk_dec[1]) + LEVEL_OFFSET
                 - level_t'(pk_half[0]) - level_t'(pk_half[2]);
        lvl[2] = level_t'(pk_dec[2]) + LEVEL_OFFSET
                 - level_t'(pk_half[0]) - level_t'(pk_half[1]);
    end

    tcm_duty u_duty_red (
        .level (lvl[0]),
        .bias  (bias_red_reg),
        .duty  (duty_w[0])
    );

    tcm_duty u_duty_green (
        .level (lvl[1]),
        .bias  (bias_green_reg),
        .duty  (duty_w[1])
    );

    tcm_duty u_duty_blue (
        .level (lvl[2]),
        .bias  (bias_blue_reg),
        .duty  (duty_w[2])
    );

    // Sample path: centre the byte by flipping its top bit, scale by four in low sensitivity.
    logic signed [7:0] centred;
    accel_t            smp_val;
    logic [10:0]       smp_mag;
    logic              wl_w;
    logic              ar_w;

    assign centred = {~in_smp_reg[7], in_smp_reg[6:0]};
    assign smp_val = low_sens_reg ? accel_t'($signed({centred, 2'b00})) : accel_t'(centred);
    assign smp_mag = peak_mag(peak_t'(smp_val));
    assign wl_w    = want_lower_reg || (smp_mag > {1'b0, lower_sens_reg});
    assign ar_w    = allow_raise_reg && !(smp_mag >= {1'b0, raise_sens_reg});

    always_comb begin
        peak_t       dev;
        logic [10:0] dev_mag;

        dev     = '0;
        dev_mag = '0;

        axis_next        = axis_reg;
        latest_next      = latest_reg;
        rest_next        = rest_reg;
        peak_next        = peak_reg;
        low_sens_next    = low_sens_reg;
        allow_raise_next = allow_raise_reg;
        want_lower_next  = want_lower_reg;
        tick_cnt_next    = tick_cnt_reg;
        duty_next        = duty_reg;

        if (adv) begin
            unique case (in_act_reg)
                ACT_SAMPLE: begin
                    latest_next[axis_reg] = smp_val;
                    if (axis_reg == AXIS_Z) begin
                        // End of a round: settle the range, then track peaks against rest.
                        axis_next        = AXIS_X;
                        low_sens_next    = wl_w || (low_sens_reg && !ar_w);
                        allow_raise_next = 1'b1;
                        want_lower_next  = 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            dev     = peak_t'(latest_next[i]) - peak_t'(rest_reg[i]);
                            dev_mag = peak_mag(dev);
                            if (dev_mag >= {1'b0, rest_thr_reg}
                                && dev_mag > peak_mag(peak_reg[i])) begin
                                peak_next[i] = dev;
                            end
                        end
                    end else begin
                        axis_next        = axis_reg + 2'd1;
                        allow_raise_next = ar_w;
                        want_lower_next  = wl_w;
                    end
                end
                ACT_TICK: begin
                    tick_cnt_next = decay_now ? 16'd0 : tick_inc;
                    peak_next     = pk_dec;
                    duty_next     = duty_w;
                end
                ACT_REST: begin
                    rest_next = latest_reg;
                end
                ACT_NONE: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_period_reg <= DECAY_PERIOD_RST;
            lower_sens_reg   <= LOWER_SENS_RST;
            raise_sens_reg   <= RAISE_SENS_RST;
            rest_thr_reg     <= REST_THR_RST;
            bias_red_reg     <= BIAS_RED_RST;
            bias_green_reg   <= BIAS_GREEN_RST;
            bias_blue_reg    <= BIAS_BLUE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DECAY_PERIOD: decay_period_reg <= cfg_wdata;
                CFG_LOWER_SENS:   lower_sens_reg   <= cfg_wdata[9:0];
                CFG_RAISE_SENS:   raise_sens_reg   <= cfg_wdata[9:0];
                CFG_REST_THR:     rest_thr_reg     <= cfg_wdata[9:0];
                CFG_BIAS_RED:     bias_red_reg     <= cfg_wdata[7:0];
                CFG_BIAS_GREEN:   bias_green_reg   <= cfg_wdata[7:0];
                CFG_BIAS_BLUE:    bias_blue_reg    <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_act_reg <= action_t'(s_action);
            in_smp_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            axis_reg        <= AXIS_X;
            latest_reg      <= '{default: '0};
            rest_reg        <= '{11'sd0, 11'sd0, REST_Z_RST};
            peak_reg        <= '{default: '0};
            low_sens_reg    <= 1'b1;
            allow_raise_reg <= 1'b1;
            want_lower_reg  <= 1'b0;
            tick_cnt_reg    <= '0;
            duty_reg        <= '{default: '0};
        end else begin
            m_valid_reg     <= m_valid_next;
            axis_reg        <= axis_next;
            latest_reg      <= latest_next;
            rest_reg        <= rest_next;
            peak_reg        <= peak_next;
            low_sens_reg    <= low_sens_next;
            allow_raise_reg <= allow_raise_next;
            want_lower_reg  <= want_lower_next;
            tick_cnt_reg    <= tick_cnt_next;
            duty_reg        <= duty_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_red_duty        = duty_reg[0];
    assign m_green_duty      = duty_reg[1];
    assign m_blue_duty       = duty_reg[2];
    assign m_low_sensitivity = low_sens_reg;
    assign m_next_axis       = axis_reg;

    // Every transaction that leaves the input register must produce a result.
    `TCM_ASSERT_NEXT(a_adv_gives_result, adv, m_valid, "processed transaction gave no result")
    // Back-pressure on the input only arises from a full input stage behind a stalled result.
    `TCM_ASSERT_NOW(a_stall_cause, !s_ready, in_vld_reg && m_valid_reg && !m_ready,
                    "input stalled without a stalled result")
    // Only axis samples advance the axis counter.
    `TCM_ASSERT_NEXT(a_axis_holds, adv && (in_act_reg != ACT_SAMPLE), $stable(axis_reg),
                     "axis counter moved on a non-sample transaction")
    // The sensitivity mode changes only at the end of a full round.
    `TCM_ASSERT_NEXT(a_mode_at_round_end,
                     !(adv && (in_act_reg == ACT_SAMPLE) && (axis_reg == AXIS_Z)),
                     $stable(low_sens_reg), "sensitivity mode changed mid-round")

endmodule
